[hw/rtl/tkns_pkg.sv]
// Shared types and constants for the top-k neighbor select block.
package tkns_pkg;

	localparam int ID_W    = 19;
	localparam int SCORE_W = 16;
	localparam int RANK_W  = 3;
	localparam int KEEP_W  = 4;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd5;

	// One candidate transaction
	typedef struct packed {
		logic [ID_W-1:0]           candidate_id;
		logic signed [SCORE_W-1:0] score;
		logic                      row_end;
	} cand_item_t;

	// One ranked neighbor transaction
	typedef struct packed {
		logic [ID_W-1:0]           neighbor_id;
		logic signed [SCORE_W-1:0] neighbor_score;
		logic [RANK_W-1:0]         rank;
		logic                      last_of_run;
	} nbr_item_t;

	// Broadcast control to every cell of the chain
	typedef struct packed {
		logic insert;  // place the broadcast candidate
		logic shift;   // move every entry one place toward the head
	} cell_ctl_t;

	// Sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

[hw/rtl/tkns_cell.sv]
// One slot of the sorted chain: holds an entry, inserts or shifts in place.
module tkns_cell #(
	parameter int IdW = 19
) (
	input  logic                                clk,
	input  tkns_pkg::cell_ctl_t                 ctl,
	input  logic                                occupied,
	input  logic [IdW-1:0]                      cand_id,
	input  logic signed [tkns_pkg::SCORE_W-1:0] cand_score,
	input  logic                                prev_take,
	input  logic [IdW-1:0]                      prev_id,
	input  logic signed [tkns_pkg::SCORE_W-1:0] prev_score,
	input  logic [IdW-1:0]                      next_id,
	input  logic signed [tkns_pkg::SCORE_W-1:0] next_score,
	output logic                                take,
	output logic [IdW-1:0]                      id,
	output logic signed [tkns_pkg::SCORE_W-1:0] score
);

	logic [IdW-1:0]                      id_q;
	logic signed [tkns_pkg::SCORE_W-1:0] score_q;

	// Candidate belongs here or above; ties stay with the earlier arrival
	assign take = !occupied || (cand_score > score_q);

	// Entry update: drain shift, push down from above, or load candidate
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			id_q    <= next_id;
			score_q <= next_score;
		end else if (ctl.insert) begin
			if (prev_take) begin
				id_q    <= prev_id;
				score_q <= prev_score;
			end else if (take) begin
				id_q    <= cand_id;
				score_q <= cand_score;
			end
		end
	end

	assign id    = id_q;
	assign score = score_q;

endmodule

[hw/rtl/top_k_neighbor_select.sv]
// Top level: keeps the best candidates of a row and emits them ranked.
//
// Candidates arrive on the cand channel (cand_valid / cand_stall), one per
// cycle while not stalled, each placed at once into a sorted chain of K_MAX
// cells by a parallel compare in every cell. Ties keep the earlier arrival.
// A transaction with row_end set is inserted like the others; from the next
// cycle on the block offers min(keep_count, kept) neighbors on the nbr
// channel in rank order, one per unstalled cycle, last one flagged last_of_run.
// Each accepted neighbor shifts the chain one cell toward the head.
// While these are offered cand_stall is high, so the next row waits until
// the drain ends; keep_count and the row's fill set the drain length, and
// the single head cell feeds the output.
// A receiver stall on nbr holds the offered neighbor unchanged.
// keep_count is written via keep_we / keep_data, by the user only while idle;
// the block does not enforce this. Zero acts as one, above K_MAX as K_MAX.
// Reset clears the row and sets keep_count to 5; kept entries need no clear.
module top_k_neighbor_select #(
	parameter int K_MAX   = 8,
	parameter int ID_BITS = 19
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cand_valid,
	output logic                           cand_stall,
	input  tkns_pkg::cand_item_t           cand,
	output logic                           nbr_valid,
	input  logic                           nbr_stall,
	output tkns_pkg::nbr_item_t            nbr,
	input  logic                           keep_we,
	input  logic [tkns_pkg::KEEP_W-1:0]    keep_data
);

	localparam int IdW = (ID_BITS < tkns_pkg::ID_W) ? ID_BITS : tkns_pkg::ID_W;
	localparam int KW  = $clog2(K_MAX + 1);
	localparam int EW  = KW + tkns_pkg::KEEP_W;

	tkns_pkg::state_t                    state_q;
	logic [tkns_pkg::KEEP_W-1:0]         keep_q;
	logic [KW-1:0]                       fill_q;
	logic [KW-1:0]                       count_q;
	logic [KW-1:0]                       rank_q;
	tkns_pkg::cell_ctl_t                 ctl;

	logic                                cand_acc;
	logic                                nbr_acc;
	logic                                last;
	logic [KW-1:0]                       fill_next;
	logic [EW-1:0]                       keep_ext;
	logic [EW-1:0]                       keep_eff;
	logic [EW-1:0]                       fill_ext;
	logic [KW-1:0]                       emit_n;
	logic [KW+2:0]                       rank_ext;

	logic [IdW-1:0]                      id_c    [K_MAX];
	logic signed [tkns_pkg::SCORE_W-1:0] score_c [K_MAX];
	logic                                take_c  [K_MAX];

	// Handshakes
	assign cand_stall = (state_q == tkns_pkg::ST_DRAIN);
	assign nbr_valid  = (state_q == tkns_pkg::ST_DRAIN);
	assign cand_acc   = cand_valid && !cand_stall;
	assign nbr_acc    = nbr_valid && !nbr_stall;
	assign last       = (KW'(rank_q + 1'b1) == count_q);

	assign ctl.insert = cand_acc;
	assign ctl.shift  = nbr_acc;

	// Entries held after this insert, and how many of them go out
	assign fill_next = (fill_q < KW'(K_MAX)) ? KW'(fill_q + 1'b1) : fill_q;
	assign keep_ext  = EW'(keep_q);
	assign fill_ext  = EW'(fill_next);
	always_comb begin
		keep_eff = keep_ext;
		if (keep_ext == '0) begin
			keep_eff = EW'(1);
		end else if (keep_ext > EW'(K_MAX)) begin
			keep_eff = EW'(K_MAX);
		end
		emit_n = (keep_eff < fill_ext) ? keep_eff[KW-1:0] : fill_next;
	end

	// Chain of cells, cell 0 holds the best entry
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		logic                                prev_take;
		logic [IdW-1:0]                      prev_id;
		logic signed [tkns_pkg::SCORE_W-1:0] prev_score;
		logic [IdW-1:0]                      next_id;
		logic signed [tkns_pkg::SCORE_W-1:0] next_score;

		if (i == 0) begin : g_head
			assign prev_take  = 1'b0;
			assign prev_id    = '0;
			assign prev_score = '0;
		end else begin : g_body
			assign prev_take  = take_c[i-1];
			assign prev_id    = id_c[i-1];
			assign prev_score = score_c[i-1];
		end

		if (i == K_MAX - 1) begin : g_tail
			assign next_id    = '0;
			assign next_score = '0;
		end else begin : g_mid
			assign next_id    = id_c[i+1];
			assign next_score = score_c[i+1];
		end

		tkns_cell #(
			.IdW(IdW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (KW'(i) < fill_q),
			.cand_id   (cand.candidate_id[IdW-1:0]),
			.cand_score(cand.score),
			.prev_take (prev_take),
			.prev_id   (prev_id),
			.prev_score(prev_score),
			.next_id   (next_id),
			.next_score(next_score),
			.take      (take_c[i]),
			.id        (id_c[i]),
			.score     (score_c[i])
		);
	end

	// Output transaction comes straight from the head cell
	assign rank_ext           = {3'b000, rank_q};
	assign nbr.neighbor_id    = tkns_pkg::ID_W'(id_c[0]);
	assign nbr.neighbor_score = score_c[0];
	assign nbr.rank           = rank_ext[tkns_pkg::RANK_W-1:0];
	assign nbr.last_of_run    = last;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= tkns_pkg::KEEP_RESET;
		end else if (keep_we) begin
			keep_q <= keep_data;
		end
	end

	// Row sequencer: fill on candidates, drain after row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkns_pkg::ST_FILL;
			fill_q  <= '0;
			count_q <= '0;
			rank_q  <= '0;
		end else begin
			case (state_q)
				tkns_pkg::ST_FILL: begin
					if (cand_acc) begin
						fill_q <= fill_next;
						if (cand.row_end) begin
							state_q <= tkns_pkg::ST_DRAIN;
							count_q <= emit_n;
							rank_q  <= '0;
						end
					end
				end
				tkns_pkg::ST_DRAIN: begin
					if (nbr_acc) begin
						rank_q <= KW'(rank_q + 1'b1);
						if (last) begin
							state_q <= tkns_pkg::ST_FILL;
							fill_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= tkns_pkg::ST_FILL;
					fill_q  <= '0;
				end
			endcase
		end
	end

endmodule
